[hw/rtl/voxel_hit_count_table_top_assert.svh]
// ----------------------------------------------------------------------------
// Voxel hit-count table assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef VOXEL_HIT_COUNT_TABLE_TOP_ASSERT_SVH
`define VOXEL_HIT_COUNT_TABLE_TOP_ASSERT_SVH

// condition must hold at every edge out of reset
`define VHCT_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define VHCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/vhct_pkg.sv]
// ----------------------------------------------------------------------------
// Voxel hit-count table package
// Types, command codes and constants shared by the table modules.
// ----------------------------------------------------------------------------
package vhct_pkg;

  localparam int COORD_BITS        = 24;
  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int SET_WAYS_DEF      = 4;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 32;
  localparam int NEAR_SQ_MM        = 9000000;

  localparam logic [2:0][26:0] PRIMES = {27'd83492791, 27'd19349663, 27'd73856093};

  localparam logic [7:0]  CLEAR_DECAY = 8'd3;
  localparam logic [12:0] REMOVED_MAX = 13'd8191;

  localparam logic [2:0] CMD_UPDATE = 3'd0;
  localparam logic [2:0] CMD_QUERY  = 3'd1;
  localparam logic [2:0] CMD_CLEAR  = 3'd2;
  localparam logic [2:0] CMD_SWEEP  = 3'd3;
  localparam logic [2:0] CMD_CHECK  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOXEL_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIME    = 2'd3;

  localparam logic        RST_FILTER_ENABLE = 1'b0;
  localparam logic [15:0] RST_VOXEL_SIZE    = 16'd100;
  localparam logic [7:0]  RST_HIT_THRESHOLD = 8'd5;
  localparam logic [31:0] RST_STALE_TIME    = 32'd5000;

  typedef struct packed {
    logic [2:0]                   command;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [31:0]                  time_now_ms;
    logic                         in_protected_box;
  } vhct_in_t;

  typedef struct packed {
    logic        voxel_found;
    logic        is_static;
    logic        keep_point;
    logic [7:0]  count_after;
    logic        table_full;
    logic [12:0] removed_count;
  } vhct_out_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [7:0]  hits;
    logic [31:0] seen_ms;
  } vhct_entry_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic div_step;
    logic mul;
    logic hash;
    logic mod_step;
    logic way_rd;
    logic way_chk;
    logic sw_rd;
    logic sw_chk;
    logic exec;
    logic ld_out;
  } vhct_cmd_t;

  typedef struct packed {
    logic is_sweep;
    logic div_last;
    logic mod_last;
    logic way_last;
    logic addr_last;
  } vhct_status_t;

endpackage

[hw/rtl/vhct_ram.sv]
// ----------------------------------------------------------------------------
// Voxel hit-count table RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module vhct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/vhct_ctrl.sv]
// ----------------------------------------------------------------------------
// Voxel hit-count table controller
// Sequences clear pass, division, hashing, set lookup, sweep and result.
// ----------------------------------------------------------------------------
module vhct_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  vhct_pkg::vhct_status_t status_i,
  output vhct_pkg::vhct_cmd_t    cmd_o
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_HASH  = 4'd4;
  localparam logic [3:0] S_MOD   = 4'd5;
  localparam logic [3:0] S_RD    = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_SWRD  = 4'd8;
  localparam logic [3:0] S_SWCHK = 4'd9;
  localparam logic [3:0] S_EXEC  = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.addr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        if (status_i.is_sweep) begin
          state_d = S_SWRD;
        end else begin
          cmd_o.div_step = 1'b1;
          if (status_i.div_last) state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_HASH;
      end
      S_HASH: begin
        cmd_o.hash = 1'b1;
        state_d    = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) state_d = S_RD;
      end
      S_RD: begin
        cmd_o.way_rd = 1'b1;
        state_d      = S_CHK;
      end
      S_CHK: begin
        cmd_o.way_chk = 1'b1;
        state_d       = status_i.way_last ? S_EXEC : S_RD;
      end
      S_SWRD: begin
        cmd_o.sw_rd = 1'b1;
        state_d     = S_SWCHK;
      end
      S_SWCHK: begin
        cmd_o.sw_chk = 1'b1;
        state_d      = status_i.addr_last ? S_EXEC : S_SWRD;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.ld_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/vhct_datapath.sv]
// ----------------------------------------------------------------------------
// Voxel hit-count table datapath
// Config registers, serial dividers, hash, set modulo, lookup and update.
// ----------------------------------------------------------------------------
module vhct_datapath #(
  parameter int TableEntries = vhct_pkg::TABLE_ENTRIES_DEF,
  parameter int SetWays      = vhct_pkg::SET_WAYS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vhct_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [vhct_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  vhct_pkg::vhct_in_t                  in_data_i,
  input  vhct_pkg::vhct_cmd_t                 cmd_i,
  output vhct_pkg::vhct_status_t              status_o,
  output vhct_pkg::vhct_out_t                 out_data_o,
  output logic                                ram_we_o,
  output logic [$clog2(TableEntries)-1:0]     ram_waddr_o,
  output vhct_pkg::vhct_entry_t               ram_wdata_o,
  output logic [$clog2(TableEntries)-1:0]     ram_raddr_o,
  input  vhct_pkg::vhct_entry_t               ram_rdata_i
);

  localparam int NumSets = TableEntries / SetWays;
  localparam int AW      = $clog2(TableEntries);
  localparam int RW      = $clog2(NumSets + 1);
  localparam int CW      = (AW > 6) ? AW : 6;
  localparam int C       = vhct_pkg::COORD_BITS;
  localparam int PW      = C + 29;
  localparam int SW      = 2 * C + 1;
  localparam int NB      = $clog2(NumSets);
  localparam int TW      = RW + 8;
  localparam int MW      = 2 * TW + 1;
  localparam int SH      = TW + NB;
  localparam logic [63:0] MREC64 =
    ((64'd1 << SH) + 64'(NumSets) - 64'd1) / 64'(NumSets);
  localparam logic [TW:0] MREC = MREC64[TW:0];

  // configuration
  logic        fe_q;
  logic [15:0] vs_q;
  logic [7:0]  thr_q;
  logic [31:0] stale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_q    <= vhct_pkg::RST_FILTER_ENABLE;
      vs_q    <= vhct_pkg::RST_VOXEL_SIZE;
      thr_q   <= vhct_pkg::RST_HIT_THRESHOLD;
      stale_q <= vhct_pkg::RST_STALE_TIME;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vhct_pkg::CFG_FILTER_ENABLE: fe_q    <= cfg_wdata_i[0];
        vhct_pkg::CFG_VOXEL_SIZE:    vs_q    <= cfg_wdata_i[15:0];
        vhct_pkg::CFG_HIT_THRESHOLD: thr_q   <= cfg_wdata_i[7:0];
        vhct_pkg::CFG_STALE_TIME:    stale_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  vhct_pkg::vhct_in_t    in_q;
  logic [CW-1:0]         cnt_q;
  logic [C-1:0]          mag_q [3];
  logic                  neg_q [3];
  logic [15:0]           dr_q  [3];
  logic [63:0]           prod_q [3];
  logic [2*C-1:0]        sqx_q, sqy_q;
  logic [63:0]           key_q, mod_sh_q;
  logic                  near_q;
  logic [RW-1:0]         mod_r_q;
  logic [7:0]            mod_qt_q;
  logic                  hit_q, free_q;
  logic [AW-1:0]         hit_idx_q, free_idx_q;
  vhct_pkg::vhct_entry_t hit_e_q;
  logic [12:0]           rem_q;
  vhct_pkg::vhct_out_t   res_q, out_q;

  logic signed [C-1:0] coord_in [3];
  logic [15:0]         dv;
  logic [C-1:0]        mag_d [3];
  logic [15:0]         dr_d  [3];
  logic [63:0]         prod_d [3];
  logic [C-1:0]        ax, ay;
  logic [63:0]         key_d;
  logic [TW-1:0]       mod_t, mod_qn;
  logic [MW-1:0]       mod_p;
  logic [RW-1:0]       mod_r_d;
  logic [AW-1:0]       base, way_addr;
  logic                stale;

  // command execution
  vhct_pkg::vhct_out_t   res_d;
  logic                  ex_we;
  logic [AW-1:0]         ex_idx;
  vhct_pkg::vhct_entry_t ex_e;
  logic [7:0]            h0, h1, c3;
  logic [8:0]            lim;
  logic                  inc;

  assign coord_in[0] = in_data_i.point_x;
  assign coord_in[1] = in_data_i.point_y;
  assign coord_in[2] = in_data_i.point_z;
  assign dv          = (vs_q == 16'd0) ? 16'd1 : vs_q;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [16:0]          t, tsub;
    logic                 ge;
    logic [C:0]           qext, idx;
    logic signed [PW-1:0] p;
    always_comb begin
      t        = {dr_q[i], mag_q[i][C-1]};
      tsub     = t - {1'b0, dv};
      ge       = (t >= {1'b0, dv});
      dr_d[i]  = ge ? tsub[15:0] : t[15:0];
      mag_d[i] = {mag_q[i][C-2:0], ge};
      qext     = {1'b0, mag_q[i]};
      idx      = neg_q[i] ? (~qext + (C+1)'(dr_q[i] == 16'd0)) : qext;
      p        = $signed(idx) * $signed({1'b0, vhct_pkg::PRIMES[i]});
      prod_d[i] = {{(64-PW){p[PW-1]}}, p};
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        neg_q[i] <= coord_in[i][C-1];
        mag_q[i] <= coord_in[i][C-1] ? C'(~coord_in[i] + 1'b1) : C'(coord_in[i]);
        dr_q[i]  <= 16'd0;
      end else if (cmd_i.div_step) begin
        mag_q[i] <= mag_d[i];
        dr_q[i]  <= dr_d[i];
      end
      if (cmd_i.mul) prod_q[i] <= prod_d[i];
    end
  end

  assign ax = in_q.point_x[C-1] ? C'(~in_q.point_x + 1'b1) : C'(in_q.point_x);
  assign ay = in_q.point_y[C-1] ? C'(~in_q.point_y + 1'b1) : C'(in_q.point_y);

  assign key_d   = prod_q[0] ^ prod_q[1] ^ prod_q[2];

  // set index: folded key taken a byte at a time, quotient digit by reciprocal
  // multiplication, then remainder by subtraction
  assign mod_t   = {mod_r_q, mod_sh_q[63:56]};
  assign mod_p   = MW'(mod_t) * MW'(MREC);
  assign mod_qn  = TW'(mod_qt_q) * TW'(NumSets);
  assign mod_r_d = RW'(mod_t - mod_qn);

  assign base    = AW'(mod_r_q) * AW'(SetWays);
  assign way_addr = base + cnt_q[AW-1:0];

  assign stale = ram_rdata_i.valid && (in_q.time_now_ms > ram_rdata_i.seen_ms) &&
                 ((in_q.time_now_ms - ram_rdata_i.seen_ms) > stale_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_data_i;
    if (cmd_i.mul) begin
      sqx_q <= ax * ax;
      sqy_q <= ay * ay;
    end
    if (cmd_i.hash) begin
      key_q    <= key_d;
      mod_sh_q <= key_d ^ {32'd0, key_d[63:32]};
      mod_r_q  <= '0;
      near_q   <= ({1'b0, sqx_q} + {1'b0, sqy_q}) < SW'(vhct_pkg::NEAR_SQ_MM);
    end else if (cmd_i.mod_step) begin
      if (!cnt_q[0]) begin
        mod_qt_q <= mod_p[SH +: 8];
      end else begin
        mod_sh_q <= {mod_sh_q[55:0], 8'd0};
        mod_r_q  <= mod_r_d;
      end
    end
    if (cmd_i.way_chk) begin
      if (ram_rdata_i.valid && ram_rdata_i.key == key_q && !hit_q) begin
        hit_idx_q <= way_addr;
        hit_e_q   <= ram_rdata_i;
      end
      if (!ram_rdata_i.valid && !free_q) free_idx_q <= way_addr;
    end
    if (cmd_i.exec) res_q <= res_d;
    if (cmd_i.ld_out) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
        rem_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= status_o.div_last ? '0 : cnt_q + 1'b1;
      end else if (cmd_i.mod_step) begin
        cnt_q <= status_o.mod_last ? '0 : cnt_q + 1'b1;
      end else if (cmd_i.way_chk) begin
        cnt_q <= status_o.way_last ? '0 : cnt_q + 1'b1;
      end else if (cmd_i.sw_chk || cmd_i.clr_wr) begin
        cnt_q <= status_o.addr_last ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.hash) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.way_chk) begin
        if (ram_rdata_i.valid && ram_rdata_i.key == key_q) hit_q <= 1'b1;
        if (!ram_rdata_i.valid) free_q <= 1'b1;
      end
      if (cmd_i.sw_chk && stale && rem_q != vhct_pkg::REMOVED_MAX) rem_q <= rem_q + 13'd1;
    end
  end

  always_comb begin
    res_d            = '0;
    res_d.keep_point = 1'b1;
    ex_we            = 1'b0;
    ex_idx           = hit_idx_q;
    ex_e             = hit_e_q;
    h0               = hit_q ? hit_e_q.hits : 8'd0;
    lim              = {1'b0, thr_q} + 9'd1;
    inc              = !near_q || !h0[0];
    h1               = (inc && {1'b0, h0} <= lim && h0 != 8'hFF) ? h0 + 8'd1 : h0;
    c3               = (hit_e_q.hits > vhct_pkg::CLEAR_DECAY) ?
                       hit_e_q.hits - vhct_pkg::CLEAR_DECAY : 8'd0;
    unique case (in_q.command)
      vhct_pkg::CMD_UPDATE: begin
        if (hit_q || free_q) begin
          ex_we             = 1'b1;
          ex_idx            = hit_q ? hit_idx_q : free_idx_q;
          ex_e              = '{valid: 1'b1, key: key_q, hits: h1, seen_ms: in_q.time_now_ms};
          res_d.voxel_found = hit_q;
          res_d.count_after = h1;
          res_d.is_static   = h1 > thr_q;
        end else begin
          res_d.table_full = 1'b1;
        end
      end
      vhct_pkg::CMD_QUERY, vhct_pkg::CMD_CHECK: begin
        if (hit_q) begin
          res_d.voxel_found = 1'b1;
          res_d.count_after = hit_e_q.hits;
          res_d.is_static   = hit_e_q.hits > thr_q;
          if (in_q.command == vhct_pkg::CMD_QUERY && fe_q && res_d.is_static) begin
            if (in_q.in_protected_box) begin
              res_d.count_after = hit_e_q.hits - 8'd1;
              ex_we             = 1'b1;
              ex_e.hits         = hit_e_q.hits - 8'd1;
            end else begin
              res_d.keep_point = 1'b0;
            end
          end
        end
      end
      vhct_pkg::CMD_CLEAR: begin
        if (hit_q) begin
          ex_we               = 1'b1;
          ex_e.hits           = c3;
          ex_e.valid          = (c3 != 8'd0);
          res_d.voxel_found   = 1'b1;
          res_d.count_after   = c3;
          res_d.removed_count = (c3 == 8'd0) ? 13'd1 : 13'd0;
          res_d.is_static     = (c3 != 8'd0) && (c3 > thr_q);
        end
      end
      vhct_pkg::CMD_SWEEP: res_d.removed_count = rem_q;
      default: ;
    endcase
  end

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q[AW-1:0];
    ram_wdata_o = '0;
    if (cmd_i.clr_wr) begin
      ram_we_o = 1'b1;
    end else if (cmd_i.sw_chk) begin
      ram_we_o = stale;
    end else if (cmd_i.exec) begin
      ram_we_o    = ex_we;
      ram_waddr_o = ex_idx;
      ram_wdata_o = ex_e;
    end
  end

  assign ram_raddr_o = cmd_i.sw_rd ? cnt_q[AW-1:0] : way_addr;

  assign status_o.is_sweep  = (in_q.command == vhct_pkg::CMD_SWEEP);
  assign status_o.div_last  = (cnt_q == CW'(C - 1));
  assign status_o.mod_last  = (cnt_q == CW'(2 * 8 - 1));
  assign status_o.way_last  = (cnt_q == CW'(SetWays - 1));
  assign status_o.addr_last = (cnt_q == CW'(TableEntries - 1));

  assign out_data_o = out_q;

endmodule

[hw/rtl/voxel_hit_count_table_top.sv]
// ----------------------------------------------------------------------------
// Voxel hit-count table
// Spatial-hash voxel occupancy counter with set-associative table.
// ----------------------------------------------------------------------------
// After reset the block walks the table once to clear it, with the input
// stalled. A point command runs through a bit-serial floor divider per axis,
// one multiply stage for the prime hash, a set modulo that folds the key in
// one byte at a time, and a read and a check of each way in turn through the
// table's single read port. A sweep reads every entry. One beat is in work at
// a time; the next beat can be taken in the same cycle that a result is
// presented, also while that result waits on stall. A finished result waits
// while the output holds an unaccepted one.
module voxel_hit_count_table_top #(
  parameter int TableEntries = vhct_pkg::TABLE_ENTRIES_DEF,
  parameter int SetWays      = vhct_pkg::SET_WAYS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vhct_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vhct_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  vhct_pkg::vhct_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output vhct_pkg::vhct_out_t             out_data_o
);

  localparam int AW = $clog2(TableEntries);

  vhct_pkg::vhct_cmd_t    cmd;
  vhct_pkg::vhct_status_t status;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  vhct_pkg::vhct_entry_t  ram_wdata, ram_rdata;

  vhct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vhct_datapath #(
    .TableEntries (TableEntries),
    .SetWays      (SetWays)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  vhct_ram #(
    .Width ($bits(vhct_pkg::vhct_entry_t)),
    .Depth (TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[hw/rtl/vhct_checker.sv]
// ----------------------------------------------------------------------------
// Voxel hit-count table port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "voxel_hit_count_table_top_assert.svh"

module vhct_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input vhct_pkg::vhct_out_t out_data_o
);

  `VHCT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled beat changed")
  `VHCT_ASSERT_NOW(a_drop_static, !(out_valid_o && !out_data_o.keep_point) || (out_data_o.is_static && out_data_o.voxel_found), "drop without static voxel")
  `VHCT_ASSERT_NOW(a_full_empty, !(out_valid_o && out_data_o.table_full) || (!out_data_o.voxel_found && out_data_o.count_after == 8'd0), "full set with entry data")
  `VHCT_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o, "input taken while busy")

endmodule

bind voxel_hit_count_table_top vhct_checker u_vhct_checker (.*);

[tb/sv/voxel_hit_count_table_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voxel hit-count table testbench
// Drives point commands through the valid/stall channels and compares every
// result beat with a behavioral table model kept in a small scoreboard.
// Covers directed corner cases, a full set, then randomized traffic on a hot
// voxel pool under several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module voxel_hit_count_table_top_tb;

  localparam int NUM_ENTRIES = 4096;
  localparam int NUM_WAYS    = 4;
  localparam int NUM_SETS    = NUM_ENTRIES / NUM_WAYS;
  localparam int CRD_W       = vhct_pkg::COORD_BITS;
  localparam int IN_W        = $bits(vhct_pkg::vhct_in_t);
  localparam int IDX_W       = vhct_pkg::CFG_IDX_W;
  localparam logic [63:0] HASH_PX = 64'd73856093;
  localparam logic [63:0] HASH_PY = 64'd19349663;
  localparam logic [63:0] HASH_PZ = 64'd83492791;
  localparam logic [63:0] NEAR_LIMIT = 64'd9000000;

  class voxel_table_sb;
    bit          filt_en;
    logic [15:0] vsize;
    logic [7:0]  thresh;
    logic [31:0] stale;
    bit          v_ok [NUM_ENTRIES];
    logic [63:0] v_key [NUM_ENTRIES];
    logic [7:0]  v_hits [NUM_ENTRIES];
    logic [31:0] v_seen [NUM_ENTRIES];
    vhct_pkg::vhct_out_t pending_q[$];
    int          errors;

    function new();
      filt_en = vhct_pkg::RST_FILTER_ENABLE;
      vsize   = vhct_pkg::RST_VOXEL_SIZE;
      thresh  = vhct_pkg::RST_HIT_THRESHOLD;
      stale   = vhct_pkg::RST_STALE_TIME;
      errors  = 0;
      foreach (v_ok[i]) v_ok[i] = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        vhct_pkg::CFG_FILTER_ENABLE: filt_en = val[0];
        vhct_pkg::CFG_VOXEL_SIZE:    vsize   = val[15:0];
        vhct_pkg::CFG_HIT_THRESHOLD: thresh  = val[7:0];
        default:                     stale   = val;
      endcase
    endfunction

    function longint floor_div(longint a, longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && a < 0) q--;
      return q;
    endfunction

    function logic [63:0] voxel_key(logic signed [CRD_W-1:0] x,
                                    logic signed [CRD_W-1:0] y,
                                    logic signed [CRD_W-1:0] z);
      longint d;
      logic [63:0] kx, ky, kz;
      d  = (vsize == 0) ? 1 : longint'(vsize);
      kx = 64'(floor_div(longint'(x), d)) * HASH_PX;
      ky = 64'(floor_div(longint'(y), d)) * HASH_PY;
      kz = 64'(floor_div(longint'(z), d)) * HASH_PZ;
      return kx ^ ky ^ kz;
    endfunction

    function int set_base(logic [63:0] key);
      logic [63:0] f;
      f = key ^ (key >> 32);
      return int'(f % NUM_SETS) * NUM_WAYS;
    endfunction

    function void note_input(vhct_pkg::vhct_in_t b);
      vhct_pkg::vhct_out_t r;
      logic [63:0] key, ax, ay;
      int          base, e;
      int unsigned h;
      bit          inc;
      longint      age;
      r = '0;
      r.keep_point = 1'b1;
      key  = voxel_key(b.point_x, b.point_y, b.point_z);
      base = set_base(key);
      e = -1;
      for (int w = 0; w < NUM_WAYS; w++)
        if (e < 0 && v_ok[base+w] && v_key[base+w] == key) e = base + w;
      case (b.command)
        vhct_pkg::CMD_UPDATE: begin
          if (e < 0) begin
            for (int w = 0; w < NUM_WAYS; w++)
              if (e < 0 && !v_ok[base+w]) e = base + w;
            if (e >= 0) begin
              v_ok[e] = 1; v_key[e] = key; v_hits[e] = 0;
            end else begin
              r.table_full = 1'b1;
            end
          end else begin
            r.voxel_found = 1'b1;
          end
          if (e >= 0) begin
            ax = 64'(b.point_x < 0 ? -longint'(b.point_x) : longint'(b.point_x));
            ay = 64'(b.point_y < 0 ? -longint'(b.point_y) : longint'(b.point_y));
            h = v_hits[e];
            inc = 1;
            v_seen[e] = b.time_now_ms;
            if (ax * ax + ay * ay < NEAR_LIMIT) inc = (h % 2) == 0;
            if (inc && h <= thresh + 1 && h < 255) h++;
            v_hits[e] = h[7:0];
            r.count_after = h[7:0];
            r.is_static = h > thresh;
          end
        end
        vhct_pkg::CMD_QUERY, vhct_pkg::CMD_CHECK: begin
          if (e >= 0) begin
            r.voxel_found = 1'b1;
            r.count_after = v_hits[e];
            r.is_static = v_hits[e] > thresh;
          end
          if (b.command == vhct_pkg::CMD_QUERY && filt_en && r.is_static) begin
            if (b.in_protected_box) begin
              if (r.count_after > 0) r.count_after--;
              v_hits[e] = r.count_after;
            end else begin
              r.keep_point = 1'b0;
            end
          end
        end
        vhct_pkg::CMD_CLEAR: begin
          if (e >= 0) begin
            r.voxel_found = 1'b1;
            r.count_after = v_hits[e] > vhct_pkg::CLEAR_DECAY ?
                            v_hits[e] - vhct_pkg::CLEAR_DECAY : 8'd0;
            v_hits[e] = r.count_after;
            if (r.count_after == 0) begin
              v_ok[e] = 0;
              r.removed_count = 13'd1;
            end else begin
              r.is_static = r.count_after > thresh;
            end
          end
        end
        vhct_pkg::CMD_SWEEP: begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            age = longint'(b.time_now_ms) - longint'(v_seen[i]);
            if (v_ok[i] && age > longint'(stale)) begin
              v_ok[i] = 0;
              if (r.removed_count < vhct_pkg::REMOVED_MAX) r.removed_count++;
            end
          end
        end
        default: ;
      endcase
      pending_q = {pending_q, r};
    endfunction

    function void check_result(vhct_pkg::vhct_out_t a);
      vhct_pkg::vhct_out_t x;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending: %p", a);
        errors++;
        return;
      end
      x = pending_q.pop_front();
      if (a.voxel_found !== x.voxel_found) begin
        $error("voxel_found exp %0d got %0d", x.voxel_found, a.voxel_found); errors++;
      end
      if (a.is_static !== x.is_static) begin
        $error("is_static exp %0d got %0d", x.is_static, a.is_static); errors++;
      end
      if (a.keep_point !== x.keep_point) begin
        $error("keep_point exp %0d got %0d", x.keep_point, a.keep_point); errors++;
      end
      if (a.count_after !== x.count_after) begin
        $error("count_after exp %0d got %0d", x.count_after, a.count_after); errors++;
      end
      if (a.table_full !== x.table_full) begin
        $error("table_full exp %0d got %0d", x.table_full, a.table_full); errors++;
      end
      if (a.removed_count !== x.removed_count) begin
        $error("removed_count exp %0d got %0d", x.removed_count, a.removed_count);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [IDX_W-1:0]                cfg_idx_i = '0;
  logic [vhct_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  vhct_pkg::vhct_in_t              in_data_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  vhct_pkg::vhct_out_t             out_data_o;

  voxel_table_sb sb = new();
  int          beats_in = 0;
  int          src_idle_pct = 0;
  int          dst_stall_pct = 0;
  logic [31:0] clock_ms = 32'd1000;
  vhct_pkg::vhct_in_t hot_pool [24];

  voxel_hit_count_table_top dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_input(in_data_i);
      beats_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < dst_stall_pct);

  task automatic send_beat(vhct_pkg::vhct_in_t b);
    int target;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    target = beats_in + 1;
    in_valid_i = 1'b1;
    in_data_i  = b;
    do @(negedge clk_i); while (beats_in < target);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic vhct_pkg::vhct_in_t mk(logic [2:0] cmd, int x, int y, int z,
                                            logic [31:0] t, bit prot);
    vhct_pkg::vhct_in_t b;
    b.command = cmd;
    b.point_x = x[CRD_W-1:0];
    b.point_y = y[CRD_W-1:0];
    b.point_z = z[CRD_W-1:0];
    b.time_now_ms = t;
    b.in_protected_box = prot;
    return b;
  endfunction

  function automatic vhct_pkg::vhct_in_t random_beat();
    vhct_pkg::vhct_in_t b;
    int sel;
    sel = $urandom_range(99);
    b = hot_pool[$urandom_range(23)];
    if ($urandom_range(3) == 0) b.point_z = b.point_z + CRD_W'($urandom_range(40));
    clock_ms = clock_ms + $urandom_range(900);
    b.time_now_ms = ($urandom_range(49) == 0) ? $urandom : clock_ms;
    b.in_protected_box = 1'($urandom_range(1));
    if (sel < 40)      b.command = vhct_pkg::CMD_UPDATE;
    else if (sel < 60) b.command = vhct_pkg::CMD_QUERY;
    else if (sel < 70) b.command = vhct_pkg::CMD_CLEAR;
    else if (sel < 80) b.command = vhct_pkg::CMD_CHECK;
    else if (sel < 83) b.command = vhct_pkg::CMD_SWEEP;
    else if (sel < 85) b.command = 3'($urandom_range(7, 5));
    else begin
      b = vhct_pkg::vhct_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
      b.command = 3'($urandom_range(4));
      if (b.command == vhct_pkg::CMD_SWEEP) b.command = vhct_pkg::CMD_UPDATE;
    end
    return b;
  endfunction

  initial begin
    #(12 * 3_000_000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int same_set [$];
    int base0;
    int ix;
    logic [31:0] cfg_sets [4][4];

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: corner points, every command, filter decisions
    write_reg(vhct_pkg::CFG_FILTER_ENABLE, 32'd1);
    write_reg(vhct_pkg::CFG_HIT_THRESHOLD, 32'd0);
    send_beat(mk(3'd5, 1, 2, 3, 32'd7, 1'b1));
    send_beat(mk(3'd7, -1, -2, -3, 32'hFFFF_FFFF, 1'b0));
    send_beat(mk(vhct_pkg::CMD_UPDATE, 8388607, 8388607, 8388607, 32'd100, 1'b0));
    send_beat(mk(vhct_pkg::CMD_UPDATE, -8388608, -8388608, -8388608, 32'd100, 1'b1));
    send_beat(mk(vhct_pkg::CMD_QUERY, 8388607, 8388607, 8388607, 32'd0, 1'b1));
    send_beat(mk(vhct_pkg::CMD_UPDATE, 8388607, 8388607, 8388607, 32'd200, 1'b0));
    send_beat(mk(vhct_pkg::CMD_QUERY, 8388607, 8388607, 8388607, 32'd0, 1'b0));
    send_beat(mk(vhct_pkg::CMD_CHECK, -8388608, -8388608, -8388608, 32'd0, 1'b0));
    send_beat(mk(vhct_pkg::CMD_UPDATE, 0, 0, 0, 32'd300, 1'b0));
    send_beat(mk(vhct_pkg::CMD_UPDATE, 10, -10, 5, 32'd310, 1'b0));
    send_beat(mk(vhct_pkg::CMD_UPDATE, -50, 20, 0, 32'd320, 1'b0));
    send_beat(mk(vhct_pkg::CMD_CLEAR, 0, 0, 0, 32'd0, 1'b0));
    send_beat(mk(vhct_pkg::CMD_CLEAR, 5000, 5000, 5000, 32'd0, 1'b0));
    send_beat(mk(vhct_pkg::CMD_CLEAR, -8388608, -8388608, -8388608, 32'd0, 1'b0));
    // five voxels that hash to one set; the last insert overflows it
    base0 = sb.set_base(sb.voxel_key(CRD_W'(0), CRD_W'(0), CRD_W'(12300)));
    ix = 1;
    while (same_set.size() < 4) begin
      if (sb.set_base(sb.voxel_key(CRD_W'(ix * 100), CRD_W'(0), CRD_W'(12300))) == base0)
        same_set = {same_set, ix};
      ix++;
    end
    send_beat(mk(vhct_pkg::CMD_UPDATE, 0, 0, 12300, 32'd400, 1'b0));
    foreach (same_set[i])
      send_beat(mk(vhct_pkg::CMD_UPDATE, same_set[i] * 100, 0, 12300, 32'd400, 1'b0));
    send_beat(mk(vhct_pkg::CMD_SWEEP, 0, 0, 0, 32'd100, 1'b0));
    send_beat(mk(vhct_pkg::CMD_SWEEP, 0, 0, 0, 32'd5401, 1'b0));
    send_beat(mk(vhct_pkg::CMD_QUERY, 0, 0, 12300, 32'd0, 1'b1));
    drain();

    cfg_sets[0] = '{32'd0, 32'd100, 32'd5, 32'd5000};
    cfg_sets[1] = '{32'd1, 32'd1, 32'd0, 32'd0};
    cfg_sets[2] = '{32'd1, 32'd65535, 32'd253, 32'hFFFF_FFFF};
    cfg_sets[3] = '{32'd1, 32'd0, 32'd3, 32'd2500};

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      for (int r = 0; r < 4; r++) write_reg(r[IDX_W-1:0], cfg_sets[ph][r]);
      src_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 47 : 38) : 0;
      dst_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 47 : 38) : 0;
      foreach (hot_pool[i]) begin
        hot_pool[i] = vhct_pkg::vhct_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
        if (i < 12) begin
          hot_pool[i].point_x = CRD_W'($urandom_range(5000) - 2500);
          hot_pool[i].point_y = CRD_W'($urandom_range(5000) - 2500);
          hot_pool[i].point_z = CRD_W'($urandom_range(800) - 400);
        end
      end
      for (int n = 0; n < 185; n++) begin
        send_beat(random_beat());
        if (n == 90) drain();
      end
    end

    drain();
    repeat (200) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
